### hdl/rcc_pkg.sv
// Package: shared constants and types for the 3x3 RGB filter.
`timescale 1ns / 1ps
package rcc_pkg;
    localparam int MaxWidth     = 1024;
    localparam int CoefFracBits = 12;
    localparam int AddrW        = $clog2(MaxWidth);
    localparam int ColW         = AddrW + 1;
    localparam int RowW         = 14;
    localparam int PixW         = 24;
    localparam int CoefW        = 16;
    localparam int AccW         = 32;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_KERNEL_TOP   = 3'd2,
        REG_KERNEL_MID   = 3'd3,
        REG_KERNEL_BOT   = 3'd4
    } reg_index_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Edge masks and end mark that travel with a column down the chain.
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
        logic last;
    } edge_t;

    typedef logic signed [CoefW-1:0] coef_t;
endpackage

### hdl/rcc_if.sv
// Interfaces: input pixel channel and result channel.
`timescale 1ns / 1ps
interface rcc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, command, red, green, blue, input ready);
    modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface rcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

### hdl/rcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rcc_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/rcc_cell.sv
// Filter cell: one window column; multiplies its three pixels and adds the partial sum.
`timescale 1ns / 1ps
module rcc_cell
    import rcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [PixW-1:0]        pix_top,
    input  logic [PixW-1:0]        pix_mid,
    input  logic [PixW-1:0]        pix_bot,
    input  coef_t                  coef_top,
    input  coef_t                  coef_mid,
    input  coef_t                  coef_bot,
    input  logic                   use_top,
    input  logic                   use_bot,
    input  logic                   use_col,
    input  logic signed [AccW-1:0] acc_in [3],
    output logic signed [AccW-1:0] acc_out [3]
);
    logic signed [AccW-1:0] prod_next [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic signed [AccW-1:0] pt, pm, pb;
            pt = $signed({1'b0, pix_top[ch*8 +: 8]}) * coef_top;
            pm = $signed({1'b0, pix_mid[ch*8 +: 8]}) * coef_mid;
            pb = $signed({1'b0, pix_bot[ch*8 +: 8]}) * coef_bot;
            prod_next[ch] = acc_in[ch];
            if (use_col)
            begin
                prod_next[ch] = acc_in[ch] + pm + (use_top ? pt : '0) + (use_bot ? pb : '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_out <= prod_next;
        end
    end
endmodule

### hdl/rgb_conv3x3_clamp_core.sv
// Top level: streaming 3x3 RGB convolution with line stores and a chain of filter cells.
`timescale 1ns / 1ps
// The block takes one pixel or flush transaction per clock and returns one filtered
// result per clock once the pipeline is full, both while the output is not held back.
// Results lag the input by frame_width+1 transactions: after the last pixel of a
// frame, send frame_width+1 flush transactions to drain it; the final result
// carries frame_end. Flushes sent while pixels are still expected are dropped.
// The line stores are two RAMs with registered reads, so each transaction walks
// through a pipeline: a stage to read the line stores, one to shift the window,
// one to snapshot the window, then three filter cells (one per kernel column) that
// pass a partial sum along, and finally the clamp in front of the output register.
// The pipeline advances whenever the output register is free or being emptied,
// so the rate is one transaction per cycle while the output is not held back.
// Configuration writes take effect at once and must only happen while the block
// is idle.
module rgb_conv3x3_clamp_core
    import rcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    rcc_in_if.sink       pix_in,
    rcc_out_if.source    pix_out
);
    // Configuration registers.
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [47:0] kernel_top_reg, kernel_mid_reg, kernel_bot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 13'd768;
            kernel_top_reg   <= '0;
            kernel_mid_reg   <= 48'd4096;
            kernel_bot_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                REG_KERNEL_TOP:   kernel_top_reg   <= cfg_data;
                REG_KERNEL_MID:   kernel_mid_reg   <= cfg_data;
                REG_KERNEL_BOT:   kernel_bot_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective sizes: width saturated to 1..MaxWidth, height 0 read as 1.
    logic [ColW-1:0] eff_w;
    logic [RowW-1:0] eff_h;
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = ColW'(1);
        end
        else if (32'(frame_width_reg) > MaxWidth)
        begin
            eff_w = ColW'(MaxWidth);
        end
        else
        begin
            eff_w = ColW'(frame_width_reg);
        end
        eff_h = (frame_height_reg == '0) ? RowW'(1) : RowW'(frame_height_reg);
    end

    // Pipeline control: stage 1 (RAM read), stage 2 (window), stage 3 (snapshot),
    // stages 4..6 cells, clamp into the output register.
    localparam int Stages = 5;
    logic [Stages-1:0] vld_reg;
    logic              out_valid_reg;
    logic              adv;
    assign adv = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;

    logic accept;
    assign accept = pix_in.valid && adv;

    // Input and output position counters.
    logic [ColW-1:0] in_col_reg, out_col_reg;
    logic [RowW-1:0] in_row_reg, out_row_reg;
    logic            draining, take, emit;
    assign draining = in_row_reg >= eff_h;
    assign take     = accept && (draining || pix_in.command == CMD_PIXEL);
    assign emit     = (in_row_reg >= RowW'(2)) ||
                      (in_row_reg == RowW'(1) && in_col_reg >= ColW'(1));

    logic [PixW-1:0] fresh;
    assign fresh = draining ? '0 : {pix_in.blue, pix_in.green, pix_in.red};

    edge_t edge_next;
    always_comb
    begin
        edge_next.up    = out_row_reg == '0;
        edge_next.down  = (out_row_reg + RowW'(1)) >= eff_h;
        edge_next.left  = out_col_reg == '0;
        edge_next.right = (out_col_reg + ColW'(1)) >= eff_w;
        edge_next.last  = edge_next.right && edge_next.down;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (take)
        begin
            if (emit && edge_next.last)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (in_col_reg + ColW'(1) >= eff_w)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RowW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + ColW'(1);
                end
                if (emit)
                begin
                    if (edge_next.right)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RowW'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + ColW'(1);
                    end
                end
            end
        end
    end

    // Line stores. Read and write the same address in one transaction; the
    // write carries data for the next row, the read returns the previous rows.
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  up_rd, lo_rd;
    assign addr = in_col_reg[AddrW-1:0];

    // Stage 1 registers: the lower-store read data is registered, so both stores are
    // written from this stage, and the upper store takes that read data as its write.
    logic [AddrW-1:0] s1_addr_reg;
    logic [PixW-1:0]  s1_fresh_reg;
    logic             s1_emit_reg;
    edge_t            s1_edge_reg;

    // A read right after a write to the same address must see the new data;
    // consecutive transactions touch different columns unless width is 1.
    logic            byp_reg;
    logic [PixW-1:0] byp_up_reg, byp_lo_reg;
    logic [PixW-1:0] col_up, col_lo;
    assign col_up = byp_reg ? byp_up_reg : up_rd;
    assign col_lo = byp_reg ? byp_lo_reg : lo_rd;

    rcc_ram #(.Width(PixW), .Depth(MaxWidth)) u_ram_upper (
        .clk   (clk),
        .we    (adv && vld_reg[0]),
        .waddr (s1_addr_reg),
        .wdata (col_lo),
        .re    (take),
        .raddr (addr),
        .rdata (up_rd)
    );

    rcc_ram #(.Width(PixW), .Depth(MaxWidth)) u_ram_lower (
        .clk   (clk),
        .we    (adv && vld_reg[0]),
        .waddr (s1_addr_reg),
        .wdata (s1_fresh_reg),
        .re    (take),
        .raddr (addr),
        .rdata (lo_rd)
    );

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_addr_reg  <= addr;
            s1_fresh_reg <= fresh;
            s1_emit_reg  <= emit;
            s1_edge_reg  <= edge_next;
        end
        if (adv)
        begin
            byp_reg    <= take && vld_reg[0] && (s1_addr_reg == addr);
            byp_up_reg <= col_lo;
            byp_lo_reg <= s1_fresh_reg;
        end
    end

    // Window: three rows by three columns, shifted once per transaction.
    logic [PixW-1:0] win_reg [3][3];
    logic            s2_emit_reg;
    edge_t           s2_edge_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (adv && vld_reg[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= col_up;
            win_reg[1][2] <= col_lo;
            win_reg[2][2] <= s1_fresh_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[0])
        begin
            s2_emit_reg <= s1_emit_reg;
            s2_edge_reg <= s1_edge_reg;
        end
    end

    // Chain of cells, one per kernel column. The window is snapshotted and carried
    // along the chain, since the window keeps shifting behind it.
    logic [PixW-1:0]        snap_reg [3][3];
    logic signed [AccW-1:0] acc [4][3];
    coef_t                  ct [3], cm [3], cb [3];

    assign acc[0][0] = '0;
    assign acc[0][1] = '0;
    assign acc[0][2] = '0;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ct[c] = coef_t'(kernel_top_reg[c*CoefW +: CoefW]);
            cm[c] = coef_t'(kernel_mid_reg[c*CoefW +: CoefW]);
            cb[c] = coef_t'(kernel_bot_reg[c*CoefW +: CoefW]);
        end
    end

    // Snapshot the whole window as it enters the chain; cell k uses column k.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    snap_reg[r][c] <= win_reg[r][c];
                end
            end
        end
    end

    logic [PixW-1:0] cell_pix [3][3];
    logic [PixW-1:0] hold_reg [2][3][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hold_reg[0] <= snap_reg;
            hold_reg[1] <= hold_reg[0];
        end
    end

    // Emit/edge tracking through the chain: s2 -> snap -> c0 -> c1 -> c2.
    edge_t snap_edge_reg;
    logic  snap_emit_reg;
    logic  c_emit_reg [3];
    edge_t c_edge_reg [3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            snap_edge_reg <= s2_edge_reg;
            snap_emit_reg <= s2_emit_reg;
            c_emit_reg[0] <= snap_emit_reg;
            c_edge_reg[0] <= snap_edge_reg;
            c_emit_reg[1] <= c_emit_reg[0];
            c_edge_reg[1] <= c_edge_reg[0];
            c_emit_reg[2] <= c_emit_reg[1];
            c_edge_reg[2] <= c_edge_reg[1];
        end
    end

    // Each cell sees the masks of the transaction whose pixels it holds.
    edge_t cell_edge [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            cell_pix[0][r] = snap_reg[r][0];
            cell_pix[1][r] = hold_reg[0][r][1];
            cell_pix[2][r] = hold_reg[1][r][2];
        end
        cell_edge[0] = snap_edge_reg;
        cell_edge[1] = c_edge_reg[0];
        cell_edge[2] = c_edge_reg[1];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        edge_t e;
        assign e = cell_edge[k];
        rcc_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .pix_top  (cell_pix[k][0]),
            .pix_mid  (cell_pix[k][1]),
            .pix_bot  (cell_pix[k][2]),
            .coef_top (ct[k]),
            .coef_mid (cm[k]),
            .coef_bot (cb[k]),
            .use_top  (!e.up),
            .use_bot  (!e.down),
            .use_col  ((k == 0) ? !e.left : ((k == 2) ? !e.right : 1'b1)),
            .acc_in   (acc[k]),
            .acc_out  (acc[k+1])
        );
    end

    // Valid chain: stage 0 = s1, 1 = s2, 2 = snap, 3 = c0, 4 = c1; c2 output
    // is the stage feeding the clamp.
    logic c2_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            c2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg    <= {vld_reg[Stages-2:0], take};
            c2_vld_reg <= vld_reg[Stages-1];
        end
    end

    // Clamp: negative to 0, otherwise truncate fraction and saturate at 255.
    logic [7:0] clamp_next [3];
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [AccW-1:0] sh;
            sh = $unsigned(acc[3][ch]) >> CoefFracBits;
            if (acc[3][ch] < 0)
            begin
                clamp_next[ch] = '0;
            end
            else if (sh > AccW'(255))
            begin
                clamp_next[ch] = 8'd255;
            end
            else
            begin
                clamp_next[ch] = sh[7:0];
            end
        end
    end

    // Output register.
    logic [7:0] out_r_reg, out_g_reg, out_b_reg;
    logic       out_end_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c2_vld_reg && c_emit_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_r_reg   <= clamp_next[0];
            out_g_reg   <= clamp_next[1];
            out_b_reg   <= clamp_next[2];
            out_end_reg <= c_edge_reg[2].last;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_red   = out_r_reg;
    assign pix_out.out_green = out_g_reg;
    assign pix_out.out_blue  = out_b_reg;
    assign pix_out.frame_end = out_end_reg;
endmodule

### hdl/rcc_checker.sv
// Port-level checker for the filter core, bound to the top level.
`timescale 1ns / 1ps
module rcc_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic frame_end
);
    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Input is accepted whenever the output side is free.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Input stalls only while the output is held back.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without back-pressure");

    // A stalled result keeps its frame end mark.
    a_end_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(frame_end))
        else $error("frame end mark changed while stalled");
endmodule

bind rgb_conv3x3_clamp_core rcc_port_checker u_rcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .frame_end (pix_out.frame_end)
);

### bench/rcc_checker.sv
// Checker: mirrors the configuration, predicts filtered pixels and compares results.
`timescale 1ns / 1ps
module rcc_checker
    import rcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    rcc_in_if           in_ch,
    rcc_out_if          out_ch,
    output int          errors,
    output int          pending
);
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [47:0] kernel_rows[3];

    logic [PixW-1:0] upper_line[MaxWidth];
    logic [PixW-1:0] lower_line[MaxWidth];
    logic [PixW-1:0] window[9];
    int in_col, in_row, out_col, out_row;

    assign pending = expected_pixels.size();

    task automatic report(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Weighted sum of one color channel over the unmasked taps, clamped to a byte.
    function automatic logic [7:0] filter_channel(int shift, bit up, bit down, bit left,
                                                  bit right);
        int acc;
        coef_t coef;
        acc = 0;
        for (int kr = 0; kr < 3; kr++) begin
            if ((kr == 0 && up) || (kr == 2 && down))
                continue;
            for (int kc = 0; kc < 3; kc++) begin
                if ((kc == 0 && left) || (kc == 2 && right))
                    continue;
                coef = kernel_rows[kr][16*kc +: 16];
                acc += int'((window[kr*3 + kc] >> shift) & 8'hFF) * int'(coef);
            end
        end
        if (acc < 0)
            return 8'd0;
        acc = acc >>> CoefFracBits;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    task automatic predict_filter(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int w, h, c;
        bit draining, emit, up, down, left, right;
        logic [PixW-1:0] fresh;
        logic [PixW-1:0] column[3];
        pixel_result_t res;
        w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        draining = in_row >= h;
        // Drop a flush while pixels are still due; a pixel while draining counts as a flush.
        if (!draining && cmd == CMD_FLUSH)
            return;
        fresh = draining ? '0 : {b, g, r};
        emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
        c = in_col % MaxWidth;
        column[0] = upper_line[c];
        column[1] = lower_line[c];
        column[2] = fresh;
        upper_line[c] = column[1];
        lower_line[c] = fresh;
        for (int k = 0; k < 3; k++) begin
            window[k*3]     = window[k*3 + 1];
            window[k*3 + 1] = window[k*3 + 2];
            window[k*3 + 2] = column[k];
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit)
            return;
        up    = out_row == 0;
        down  = out_row + 1 >= h;
        left  = out_col == 0;
        right = out_col + 1 >= w;
        res.red       = filter_channel(0, up, down, left, right);
        res.green     = filter_channel(8, up, down, left, right);
        res.blue      = filter_channel(16, up, down, left, right);
        res.frame_end = right && down;
        expected_pixels.push_back(res);
        if (right && down) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (right) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n) begin
            width_reg = 11'd1024;
            height_reg = 13'd768;
            kernel_rows[0] = '0;
            kernel_rows[1] = 48'd4096;
            kernel_rows[2] = '0;
            foreach (window[i])
                window[i] = '0;
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            expected_pixels.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg = cfg_data[10:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_data[12:0];
                    REG_KERNEL_TOP:   kernel_rows[0] = cfg_data;
                    REG_KERNEL_MID:   kernel_rows[1] = cfg_data;
                    REG_KERNEL_BOT:   kernel_rows[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_filter(in_ch.command, in_ch.red, in_ch.green, in_ch.blue);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result arrived with nothing expected", $realtime);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_ch.out_red !== want.red)
                        report("out_red", out_ch.out_red, want.red);
                    if (out_ch.out_green !== want.green)
                        report("out_green", out_ch.out_green, want.green);
                    if (out_ch.out_blue !== want.blue)
                        report("out_blue", out_ch.out_blue, want.blue);
                    if (out_ch.frame_end !== want.frame_end)
                        report("frame_end", out_ch.frame_end, want.frame_end);
                end
            end
        end
    end
endmodule

### bench/tb_rgb_conv3x3_clamp_core.sv
// Testbench top: clock, reset, frame stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_rgb_conv3x3_clamp_core
    import rcc_pkg::*;
();

    localparam int IdleWait = 16;     // pipeline depth plus margin before a config write
    localparam int StallLimit = 5000; // cycles without any transaction before giving up
    localparam int RandomPixels = 1200;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    int          errors;
    int          pending;
    int          burst_left;
    int          idle_cycles;
    int          ready_percent;
    int          ready_cycles;
    int          pixels_sent;

    rcc_in_if  in_ch();
    rcc_out_if out_ch();

    rgb_conv3x3_clamp_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (in_ch),
        .pix_out   (out_ch)
    );

    rcc_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Receiver: ready odds are redrawn at random intervals, full speed included.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            ready_percent <= 100;
            ready_cycles <= 0;
        end else begin
            if (ready_cycles == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_percent <= 100;
                    1: ready_percent <= 75;
                    2: ready_percent <= 50;
                    default: ready_percent <= 25;
                endcase
                ready_cycles <= $urandom_range(50, 400);
            end else begin
                ready_cycles <= ready_cycles - 1;
            end
            out_ch.ready <= ($urandom_range(0, 99) < ready_percent);
        end
    end

    // Watchdog: count cycles with no transaction on either channel and no config write.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold the input until accepted; between bursts, sometimes open a gap.
    task automatic send(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.red     <= r;
        in_ch.green   <= g;
        in_ch.blue    <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drain everything in flight, then write one register.
    task automatic write_reg(reg_index_t idx, logic [47:0] value);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (IdleWait) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, logic [47:0] top, logic [47:0] mid,
                             logic [47:0] bot);
        write_reg(REG_FRAME_WIDTH, 48'(w));
        write_reg(REG_FRAME_HEIGHT, 48'(h));
        write_reg(REG_KERNEL_TOP, top);
        write_reg(REG_KERNEL_MID, mid);
        write_reg(REG_KERNEL_BOT, bot);
    endtask

    function automatic logic [15:0] random_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1200));
            2: return 16'(-$urandom_range(0, 600));
            default: return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    function automatic logic [47:0] random_row();
        return {random_coef(), random_coef(), random_coef()};
    endfunction

    // Send one full frame of pixels, then the drain; sprinkle dropped flushes
    // into the pixel phase and let some drain slots carry pixels instead.
    task automatic run_frame(int w_reg, int h_reg, int noise_percent);
        int w, h;
        logic [7:0] r, g, b;
        w = (w_reg == 0) ? 1 : (w_reg > MaxWidth) ? MaxWidth : w_reg;
        h = (h_reg == 0) ? 1 : h_reg;
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 99) < noise_percent)
                send(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            case ($urandom_range(0, 7))
                0: {r, g, b} = '0;
                1: {r, g, b} = '1;
                default: {r, g, b} = 24'($urandom);
            endcase
            send(CMD_PIXEL, r, g, b);
            pixels_sent++;
        end
        for (int i = 0; i <= w; i++) begin
            if ($urandom_range(0, 99) < noise_percent)
                send(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_FRAME_WIDTH;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.command <= CMD_PIXEL;
        in_ch.red     <= '0;
        in_ch.green   <= '0;
        in_ch.blue    <= '0;
        idle_cycles   <= 0;
        burst_left    = 0;
        pixels_sent   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: center tap only, 3x3 frame with extreme colors, a dropped
        // flush mid-frame and a pixel standing in for a flush in the drain.
        set_frame(3, 3, '0, 48'h0000_1000_0000, '0);
        send(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
        send(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
        send(CMD_FLUSH, 8'hAA, 8'h55, 8'hAA);
        send(CMD_PIXEL, 8'h80, 8'h7F, 8'h01);
        send(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        send(CMD_PIXEL, 8'h55, 8'hAA, 8'h55);
        send(CMD_PIXEL, 8'h01, 8'h02, 8'h04);
        send(CMD_PIXEL, 8'hFE, 8'hFD, 8'hFB);
        send(CMD_PIXEL, 8'h10, 8'h20, 8'h40);
        send(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
        send(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        send(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        send(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        // Largest positive weights everywhere: sums saturate high.
        set_frame(2, 2, '1 >> 0 & 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
        run_frame(2, 2, 0);
        // Most negative weights everywhere: sums clamp to zero.
        set_frame(2, 2, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
        run_frame(2, 2, 0);
        // Zero width and height saturate to a single pixel.
        set_frame(0, 0, random_row(), random_row(), random_row());
        run_frame(0, 0, 20);

        // A wider frame that walks many line store columns.
        set_frame(64, 4, random_row(), random_row(), random_row());
        run_frame(64, 4, 1);

        // Random frames with fresh kernels; every register rewritten per frame.
        pixels_sent = 0;
        while (pixels_sent < RandomPixels) begin
            set_frame($urandom_range(1, 12), $urandom_range(1, 10),
                      random_row(), random_row(), random_row());
            run_frame(int'(checker_i.width_reg), int'(checker_i.height_reg),
                      ($urandom_range(0, 3) == 0) ? 15 : 0);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (IdleWait) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
